@@ design/orf_pkg.sv @@
// shared widths and operation codes for the overwriting ring fifo
package orf_pkg;

	// fixed field widths
	localparam int OP_W   = 3;
	localparam int POS_W  = 4;
	localparam int DATA_W = 32;
	localparam int CNT_W  = 5;

	// built ring depth, bounded by the position and occupancy widths
	localparam int DEPTH = 16;

	// operation codes
	localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
	localparam logic [OP_W-1:0] OP_POP   = 3'd1;
	localparam logic [OP_W-1:0] OP_GET   = 3'd2;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd3;
	localparam logic [OP_W-1:0] OP_FIND  = 3'd4;

	// result status codes
	localparam logic STAT_OK   = 1'b0;
	localparam logic STAT_FAIL = 1'b1;

endpackage

@@ design/orf_if.sv @@
// channel interfaces: operation input, result output and capacity write
interface orf_in_if;
	import orf_pkg::*;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [POS_W-1:0]  position;
	logic [DATA_W-1:0] data_in;
	modport source (output valid, output op, output position, output data_in, input ready);
	modport sink   (input valid, input op, input position, input data_in, output ready);
endinterface

interface orf_out_if;
	import orf_pkg::*;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data_out;
	logic [POS_W-1:0]  found_position;
	logic              status;
	logic [CNT_W-1:0]  occupancy;
	modport source (output valid, output data_out, output found_position, output status,
		output occupancy, input ready);
	modport sink   (input valid, input data_out, input found_position, input status,
		input occupancy, output ready);
endinterface

interface orf_cfg_if;
	import orf_pkg::*;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] capacity;
	modport source (output valid, output capacity, input ready);
	modport sink   (input valid, input capacity, output ready);
endinterface

@@ design/overwriting_ring_fifo_unit.sv @@
// Overwriting ring FIFO with a programmable capacity and push, pop, get, clear and find
// operations. For push, clear and unknown codes the result is registered at the accepting
// edge. Pop and get pass through the registered read of the single slot RAM read port and
// then the output register. Find scans from the oldest entry through that same read port and
// one equality comparator, reading and then comparing each entry in turn; it reports a miss
// once all n entries have been checked, where n is the occupancy. The block takes no new
// operation until the result of the current one sits in the output register, and a result
// still waiting there blocks the input. A capacity write empties the ring; it is taken only
// while the sequencer is idle and wins over an operation offered in the same cycle. Capacity 0
// acts as 1, values beyond the ring depth act as the depth.
module overwriting_ring_fifo_unit #(
	parameter int ELEMENT_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	orf_in_if.sink    item,
	orf_out_if.source result,
	orf_cfg_if.sink   cfg
);
	import orf_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CAP_RST = (DEPTH > 31) ? 31 : DEPTH;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_RD    = 4'b0010,
		S_FREAD = 4'b0100,
		S_FCMP  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	logic [CNT_W-1:0] cap_q;
	logic [CNT_W-1:0] wp_q, wp_d;
	logic [CNT_W-1:0] rp_q, rp_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic             stat_q, stat_d;
	logic [ELEMENT_WIDTH-1:0] key_q, key_d;

	logic [CNT_W-1:0] eff_cap;
	logic             in_acc;
	logic             out_free;
	logic             cfg_acc;

	logic                     ram_we;
	logic                     ram_re;
	logic [CNT_W-1:0]         ram_raddr;
	logic [ELEMENT_WIDTH-1:0] ram_wdata;
	logic [ELEMENT_WIDTH-1:0] ram_rdata;

	logic                     res_load;
	logic [DATA_W-1:0]        res_data;
	logic [POS_W-1:0]         res_found;
	logic                     res_status;

	logic                     out_valid_q;
	logic [DATA_W-1:0]        out_data_q;
	logic [POS_W-1:0]         out_found_q;
	logic                     out_status_q;
	logic [CNT_W-1:0]         out_occ_q;

	// slot of the entry at an offset from the oldest one
	function automatic logic [CNT_W-1:0] slot_at(logic [CNT_W-1:0] rp, logic [CNT_W-1:0] off,
		logic [CNT_W-1:0] cap);
		logic [CNT_W:0] s;
		s = {1'b0, rp} + {1'b0, off};
		if (s >= {1'b0, cap}) begin
			s = s - {1'b0, cap};
		end
		return s[CNT_W-1:0];
	endfunction

	// advance a pointer around the ring
	function automatic logic [CNT_W-1:0] next_slot(logic [CNT_W-1:0] p, logic [CNT_W-1:0] cap);
		logic [CNT_W:0] s;
		s = {1'b0, p} + 1'b1;
		return (s >= {1'b0, cap}) ? '0 : s[CNT_W-1:0];
	endfunction

	// capacity clamped to the built depth
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CNT_W'(1);
		end else if (32'(cap_q) > DEPTH) begin
			eff_cap = CNT_W'(CAP_RST);
		end else begin
			eff_cap = cap_q;
		end
	end

	// handshakes: a capacity write only while idle, and it holds off the operation input
	assign out_free   = !out_valid_q || result.ready;
	assign item.ready = (state_q == S_IDLE) && out_free && !cfg.valid;
	assign in_acc     = item.valid && item.ready;
	assign cfg.ready  = (state_q == S_IDLE);
	assign cfg_acc    = cfg.valid && cfg.ready;

	assign ram_wdata = ELEMENT_WIDTH'(item.data_in);

	// sequencer and ring bookkeeping
	always_comb begin
		state_d    = state_q;
		wp_d       = wp_q;
		rp_d       = rp_q;
		count_d    = count_q;
		idx_d      = idx_q;
		stat_d     = stat_q;
		key_d      = key_q;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_raddr  = rp_q;
		res_load   = 1'b0;
		res_data   = '0;
		res_found  = '0;
		res_status = STAT_OK;

		unique case (state_q)
			S_IDLE: begin
				if (cfg_acc) begin
					wp_d    = '0;
					rp_d    = '0;
					count_d = '0;
				end else if (in_acc) begin
					case (item.op)
						OP_PUSH: begin
							ram_we   = 1'b1;
							wp_d     = next_slot(wp_q, eff_cap);
							if (count_q < eff_cap) begin
								count_d = count_q + 1'b1;
							end else begin
								rp_d = next_slot(rp_q, eff_cap);
							end
							res_load = 1'b1;
						end
						OP_POP: begin
							ram_re    = 1'b1;
							ram_raddr = rp_q;
							if (count_q == '0) begin
								stat_d = STAT_FAIL;
							end else begin
								stat_d  = STAT_OK;
								count_d = count_q - 1'b1;
								rp_d    = next_slot(rp_q, eff_cap);
							end
							state_d = S_RD;
						end
						OP_GET: begin
							ram_re    = 1'b1;
							ram_raddr = slot_at(rp_q, CNT_W'(item.position), eff_cap);
							stat_d    = (CNT_W'(item.position) >= count_q) ? STAT_FAIL : STAT_OK;
							state_d   = S_RD;
						end
						OP_CLEAR: begin
							wp_d     = '0;
							rp_d     = '0;
							count_d  = '0;
							res_load = 1'b1;
						end
						OP_FIND: begin
							key_d   = ELEMENT_WIDTH'(item.data_in);
							idx_d   = '0;
							state_d = S_FREAD;
						end
						default: begin
							res_load   = 1'b1;
							res_status = STAT_FAIL;
						end
					endcase
				end
			end
			S_RD: begin
				if (out_free) begin
					res_load   = 1'b1;
					res_status = stat_q;
					res_data   = (stat_q == STAT_OK) ? DATA_W'(ram_rdata) : '0;
					state_d    = S_IDLE;
				end
			end
			S_FREAD: begin
				ram_raddr = slot_at(rp_q, idx_q, eff_cap);
				if (idx_q == count_q) begin
					if (out_free) begin
						res_load   = 1'b1;
						res_status = STAT_FAIL;
						state_d    = S_IDLE;
					end
				end else begin
					ram_re  = 1'b1;
					state_d = S_FCMP;
				end
			end
			S_FCMP: begin
				if (ram_rdata == key_q) begin
					if (out_free) begin
						res_load  = 1'b1;
						res_found = POS_W'(idx_q);
						state_d   = S_IDLE;
					end
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = S_FREAD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cap_q   <= CNT_W'(CAP_RST);
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
			idx_q   <= '0;
			stat_q  <= STAT_OK;
		end else begin
			state_q <= state_d;
			wp_q    <= wp_d;
			rp_q    <= rp_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			stat_q  <= stat_d;
			if (cfg_acc) begin
				cap_q <= cfg.capacity;
			end
		end
	end

	// search key
	always_ff @(posedge clk) begin
		key_q <= key_d;
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (res_load) begin
			out_data_q   <= res_data;
			out_found_q  <= res_found;
			out_status_q <= res_status;
			out_occ_q    <= count_d;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.data_out       = out_data_q;
	assign result.found_position = out_found_q;
	assign result.status         = out_status_q;
	assign result.occupancy      = out_occ_q;

	orf_slot_ram #(
		.DEPTH (DEPTH),
		.WIDTH (ELEMENT_WIDTH)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(wp_q)),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (AW'(ram_raddr)),
		.rdata (ram_rdata)
	);

`ifndef SYNTHESIS
	// occupancy never exceeds the clamped capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= eff_cap)
		else $error("entry count above capacity");

	// oldest-entry pointer stays inside the ring
	a_rp_range: assert property (@(posedge clk) disable iff (!arst_n)
		rp_q < eff_cap)
		else $error("read pointer outside ring");

	// write pointer sits count entries past the oldest one
	a_wp_track: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q == slot_at(rp_q, (count_q == eff_cap) ? '0 : count_q, eff_cap))
		else $error("write pointer out of step with read pointer and count");

	// find scan index never runs past the stored entries
	a_scan_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FREAD || state_q == S_FCMP) |-> idx_q <= count_q)
		else $error("find index past entry count");
`endif

endmodule

@@ design/orf_slot_ram.sv @@
// slot storage: one write port, one read port with registered read data
module orf_slot_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
